// ===== rtl/core/alm_pkg.sv =====
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants of the linked multimap
// Slot, word and count widths, operation and status codes, sequencer states
// and the request and response bundles between sequencer and slot store.
// ----------------------------------------------------------------------------
package alm_pkg;

	localparam int SLOT_W  = 7;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 7;

	// link code meaning "no slot"
	localparam logic [SLOT_W-1:0] NULL_SLOT = 7'd127;

	typedef enum logic [1:0] {
		FN_ADD        = 2'd0,
		FN_REMOVE     = 2'd1,
		FN_SEARCH     = 2'd2,
		FN_ADD_ABSENT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_PRESENT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_SDONE,
		S_ADD_WR1,
		S_ADD_WR2,
		S_RM1,
		S_RM2,
		S_RESP
	} state_t;

	// one read address for all stores, one write port per store
	typedef struct packed {
		logic [SLOT_W-1:0] rd_slot;
		logic              kv_we;
		logic [SLOT_W-1:0] kv_slot;
		logic [WORD_W-1:0] kv_key;
		logic [WORD_W-1:0] kv_val;
		logic              nl_we;
		logic [SLOT_W-1:0] nl_slot;
		logic [SLOT_W-1:0] nl_data;
		logic              pl_we;
		logic [SLOT_W-1:0] pl_slot;
		logic [SLOT_W-1:0] pl_data;
	} mem_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] value;
		logic [SLOT_W-1:0] next;
		logic [SLOT_W-1:0] prev;
	} mem_rsp_t;

	typedef struct packed {
		logic               req;
		status_t            status;
		logic [WORD_W-1:0]  value;
		logic               vvalid;
		logic               last;
		logic [COUNT_W-1:0] count;
	} emit_t;

	// a link at or beyond the capacity counts as null
	function automatic logic slot_ok(input logic [SLOT_W-1:0] s, input int cap);
		return s < SLOT_W'(cap);
	endfunction

endpackage

// ===== rtl/core/alm_store.sv =====
// ----------------------------------------------------------------------------
// alm_store: slot memories of the linked multimap
// Key, value, next-link and prev-link arrays with one registered read address
// and one write port each. Unwritten next links read slot+1, the last null.
// ----------------------------------------------------------------------------
module alm_store import alm_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic [WORD_W-1:0] key_mem  [CAPACITY];
	logic [WORD_W-1:0] val_mem  [CAPACITY];
	logic [SLOT_W-1:0] next_mem [CAPACITY];
	logic [SLOT_W-1:0] prev_mem [CAPACITY];

	logic [CAPACITY-1:0] nl_valid_q;
	logic [WORD_W-1:0]   key_rd_q;
	logic [WORD_W-1:0]   val_rd_q;
	logic [SLOT_W-1:0]   next_rd_q;
	logic [SLOT_W-1:0]   prev_rd_q;
	logic                next_rv_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [IDX_W-1:0]    rd_idx;

	// out-of-range slots map to entry zero, their data is never used
	function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] s);
		return slot_ok(s, CAPACITY) ? s[IDX_W-1:0] : '0;
	endfunction

	assign rd_idx = to_idx(req.rd_slot);

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		if (req.kv_we) begin
			key_mem[to_idx(req.kv_slot)] <= req.kv_key;
			val_mem[to_idx(req.kv_slot)] <= req.kv_val;
		end
		if (req.nl_we) begin
			next_mem[to_idx(req.nl_slot)] <= req.nl_data;
		end
		if (req.pl_we) begin
			prev_mem[to_idx(req.pl_slot)] <= req.pl_data;
		end
		key_rd_q  <= key_mem[rd_idx];
		val_rd_q  <= val_mem[rd_idx];
		next_rd_q <= next_mem[rd_idx];
		prev_rd_q <= prev_mem[rd_idx];
		next_rv_q <= nl_valid_q[rd_idx];
		rd_idx_q  <= rd_idx;
	end

	// written marks of the next links
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_valid_q <= '0;
		end else if (req.nl_we) begin
			nl_valid_q[to_idx(req.nl_slot)] <= 1'b1;
		end
	end

	// unwritten next link reads as the reset chain
	always_comb begin
		rsp.key   = key_rd_q;
		rsp.value = val_rd_q;
		rsp.prev  = prev_rd_q;
		if (next_rv_q) begin
			rsp.next = next_rd_q;
		end else if (rd_idx_q == IDX_W'(CAPACITY - 1)) begin
			rsp.next = NULL_SLOT;
		end else begin
			rsp.next = SLOT_W'(rd_idx_q) + SLOT_W'(1);
		end
	end

endmodule

// ===== rtl/core/alm_ctrl.sv =====
// ----------------------------------------------------------------------------
// alm_ctrl: sequencer of the linked multimap
// Walks the list one slot per cycle, but for search stalls, through a shared
// key/value comparator, links and unlinks slots, and feeds the output register.
// ----------------------------------------------------------------------------
module alm_ctrl import alm_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  func_t             func,
	input  logic [WORD_W-1:0] item_key,
	input  logic [WORD_W-1:0] item_value,
	input  logic              room,
	output logic              busy,
	output mem_req_t          req,
	input  mem_rsp_t          rsp,
	output emit_t             emit
);

	localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

	state_t             state_q, state_d;
	func_t              func_q;
	logic [WORD_W-1:0]  key_q, val_q, pend_q;
	logic               pend_v_q;
	logic [SLOT_W-1:0]  cur_q, tgt_q, p_q, n_q;
	logic [SLOT_W-1:0]  head_q, free_q;
	logic [COUNT_W-1:0] count_q, steps_q;
	status_t            st_q;

	logic accept, walk_end, hit_key, hit_pair, s_block, adv, full, is_search;

	function automatic logic [SLOT_W-1:0] norm(input logic [SLOT_W-1:0] s);
		return slot_ok(s, CAPACITY) ? s : NULL_SLOT;
	endfunction

	// shared compare unit and walk control
	assign accept    = item_valid && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign is_search = (func_q == FN_SEARCH);
	assign walk_end  = !slot_ok(cur_q, CAPACITY) || (steps_q == CAP_C);
	assign hit_key   = (rsp.key == key_q);
	assign hit_pair  = hit_key && (rsp.value == val_q);
	assign s_block   = hit_key && pend_v_q && !room;
	assign adv       = !walk_end && (is_search ? !s_block : !hit_pair);
	assign full      = (count_q >= CAP_C) || !slot_ok(free_q, CAPACITY);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = (func == FN_ADD) ? S_ADD_WR1 : S_WALK;
				end
			end
			S_WALK: begin
				if (is_search) begin
					if (walk_end) state_d = S_SDONE;
				end else if (walk_end) begin
					state_d = (func_q == FN_REMOVE) ? S_RESP : S_ADD_WR1;
				end else if (hit_pair) begin
					state_d = (func_q == FN_REMOVE) ? S_RM1 : S_RESP;
				end
			end
			S_SDONE:   if (room) state_d = S_IDLE;
			S_ADD_WR1: state_d = full ? S_RESP : S_ADD_WR2;
			S_ADD_WR2: state_d = S_RESP;
			S_RM1:     state_d = S_RM2;
			S_RM2:     state_d = S_RESP;
			S_RESP:    if (room) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory requests and result items
	always_comb begin
		req         = '0;
		req.rd_slot = cur_q;
		emit        = '0;
		emit.status = ST_OK;
		emit.count  = count_q;
		case (state_q)
			S_IDLE: begin
				req.rd_slot = (func == FN_ADD) ? free_q : head_q;
			end
			S_WALK: begin
				if (adv) begin
					req.rd_slot = rsp.next;
				end else if (walk_end && func_q == FN_ADD_ABSENT) begin
					req.rd_slot = free_q;
				end
				if (is_search && adv && hit_key && pend_v_q) begin
					emit.req    = 1'b1;
					emit.value  = pend_q;
					emit.vvalid = 1'b1;
				end
			end
			S_SDONE: begin
				emit.req  = room;
				emit.last = 1'b1;
				if (pend_v_q) begin
					emit.value  = pend_q;
					emit.vvalid = 1'b1;
				end else begin
					emit.status = ST_NOT_FOUND;
				end
			end
			S_ADD_WR1: begin
				if (!full) begin
					req.kv_we   = 1'b1;
					req.kv_slot = free_q;
					req.kv_key  = key_q;
					req.kv_val  = val_q;
					req.nl_we   = 1'b1;
					req.nl_slot = free_q;
					req.nl_data = head_q;
					req.pl_we   = 1'b1;
					req.pl_slot = free_q;
					req.pl_data = NULL_SLOT;
				end
			end
			S_ADD_WR2: begin
				if (slot_ok(head_q, CAPACITY)) begin
					req.pl_we   = 1'b1;
					req.pl_slot = head_q;
					req.pl_data = tgt_q;
				end
			end
			S_RM1: begin
				if (slot_ok(p_q, CAPACITY)) begin
					req.nl_we   = 1'b1;
					req.nl_slot = p_q;
					req.nl_data = n_q;
				end
				if (slot_ok(n_q, CAPACITY)) begin
					req.pl_we   = 1'b1;
					req.pl_slot = n_q;
					req.pl_data = p_q;
				end
			end
			S_RM2: begin
				req.nl_we   = 1'b1;
				req.nl_slot = tgt_q;
				req.nl_data = free_q;
			end
			S_RESP: begin
				emit.req    = room;
				emit.status = st_q;
				emit.last   = 1'b1;
			end
			default: begin
				req.rd_slot = cur_q;
			end
		endcase
	end

	// list registers and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= NULL_SLOT;
			free_q   <= '0;
			count_q  <= '0;
			pend_v_q <= 1'b0;
			steps_q  <= '0;
			cur_q    <= NULL_SLOT;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q    <= head_q;
						steps_q  <= '0;
						pend_v_q <= 1'b0;
					end
				end
				S_WALK: begin
					if (adv) begin
						cur_q   <= rsp.next;
						steps_q <= steps_q + COUNT_W'(1);
						if (is_search && hit_key) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				S_ADD_WR1: begin
					if (!full) free_q <= rsp.next;
				end
				S_ADD_WR2: begin
					head_q  <= tgt_q;
					count_q <= count_q + COUNT_W'(1);
				end
				S_RM1: begin
					if (!slot_ok(p_q, CAPACITY)) head_q <= n_q;
				end
				S_RM2: begin
					free_q <= tgt_q;
					if (count_q != '0) count_q <= count_q - COUNT_W'(1);
				end
				default: begin
					cur_q <= cur_q;
				end
			endcase
		end
	end

	// operation payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q <= func;
					key_q  <= item_key;
					val_q  <= item_value;
				end
			end
			S_WALK: begin
				if (is_search && adv && hit_key) begin
					pend_q <= rsp.value;
				end
				if (walk_end) begin
					st_q <= ST_NOT_FOUND;
				end else if (hit_pair) begin
					st_q  <= ST_PRESENT;
					tgt_q <= cur_q;
					p_q   <= norm(rsp.prev);
					n_q   <= norm(rsp.next);
				end
			end
			S_ADD_WR1: begin
				if (full) begin
					st_q <= ST_FULL;
				end else begin
					tgt_q <= free_q;
				end
			end
			S_ADD_WR2: st_q <= ST_OK;
			S_RM2:     st_q <= ST_OK;
			default: begin
				st_q <= st_q;
			end
		endcase
	end

endmodule

// ===== rtl/core/array_linked_multimap.sv =====
// Add writes its slot with no walk; remove, search and add-if-absent first walk
// the list, up to CAPACITY slots.
// Throughput: one item at a time; the list walk takes one slot per cycle
// through the single memory read port, but a search walk holds on a match
// while the previous match still waits for room in the output register.
// Reset: asynchronous, active low; the store is empty at once, no clearing pass.
// ----------------------------------------------------------------------------
// array_linked_multimap: key-to-many-values store in linked slot arrays
// Doubly linked list of pairs with a free list of slots, one operation per
// item, with a registered result stage on the output channel.
// ----------------------------------------------------------------------------
module array_linked_multimap import alm_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] item_key,
	input  logic signed [31:0] item_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         status,
	output logic signed [31:0] found_value,
	output logic               value_valid,
	output logic               last,
	output logic [6:0]         pair_count,
	output logic               is_empty
);

	mem_req_t mreq;
	mem_rsp_t mrsp;
	emit_t    emit;
	logic     room, busy;

	// result register frees when empty or taken this cycle
	assign room       = !result_valid || !result_stall;
	assign item_stall = busy;

	alm_store #(.CAPACITY(CAPACITY)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	alm_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.func       (func_t'(func)),
		.item_key   (item_key),
		.item_value (item_value),
		.room       (room),
		.busy       (busy),
		.req        (mreq),
		.rsp        (mrsp),
		.emit       (emit)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit.req) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit.req) begin
			status      <= emit.status;
			found_value <= emit.value;
			value_valid <= emit.vvalid;
			last        <= emit.last;
			pair_count  <= emit.count;
			is_empty    <= (emit.count == '0);
		end
	end

`ifndef NO_ASSERTIONS
	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && value_valid |-> status == ST_OK)
		else $error("search match item without ok status");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !value_valid |-> last && found_value == '0)
		else $error("non-match item not final or with value");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pair_count <= 7'(CAPACITY))
		else $error("pair count beyond capacity");

	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall |-> !emit.req)
		else $error("result item issued while idle");
`endif

endmodule
